@@ hdl/adsr_pkg.sv @@
// adsr_pkg: shared types and constants of the ADSR envelope generator
// no dependencies; every other file imports it
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  // level scale: unsigned Q1.15, full scale is 1.0
  localparam logic [15:0] FULL_SCALE = 16'd32768;

  // default width of the elapsed sample counter
  localparam int ADSR_COUNT_WIDTH = 32;

  // ramp lengths, quotient and divider step count
  localparam int LEN_W   = 24;
  localparam int QUO_W   = 16;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LVL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 2'd3;

  // configuration reset values
  localparam logic [LEN_W-1:0] ATTACK_LEN_RST  = 24'd441;
  localparam logic [LEN_W-1:0] DECAY_LEN_RST   = 24'd4410;
  localparam logic [15:0]      SUSTAIN_LVL_RST = 16'd16384;
  localparam logic [LEN_W-1:0] RELEASE_LEN_RST = 24'd4410;

  // request kind
  localparam logic REQ_STEP    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // envelope phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ATTACK   = 3'd1,
    PH_DECAY    = 3'd2,
    PH_SUSTAIN  = 3'd3,
    PH_RELEASE  = 3'd4,
    PH_FINISHED = 3'd5
  } phase_t;

  // controller state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } ctrl_state_t;

  // channel payloads
  typedef struct packed {
    logic        req_type;
    logic [15:0] sample_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] level;
    logic [2:0]  phase;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic div_step;
    logic fin;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/adsr_if.sv @@
// adsr_in_if, adsr_out_if: valid/ready channels of the envelope generator
// depends on adsr_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface adsr_in_if;
  import adsr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adsr_out_if;
  import adsr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/adsr_ctrl.sv @@
// adsr_ctrl: sequencer of the envelope generator and output valid flag
// depends on adsr_pkg; drives the commands of adsr_dp
`timescale 1ns / 1ps
`default_nettype none

module adsr_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  adsr_pkg::dp_status_t    status,
  output adsr_pkg::dp_cmd_t       cmd
);
  import adsr_pkg::*;

  ctrl_state_t st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        st_nxt = status.need_div ? ST_MUL : ST_OUT;
      end
      ST_MUL:  st_nxt = ST_DIV;
      ST_DIV: begin
        if (status.div_last) st_nxt = ST_FIN;
      end
      ST_FIN:  st_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (st_r)
      ST_IDLE: cmd.load_in  = in_valid;
      ST_EVAL: cmd.eval     = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.fin      = 1'b1;
      ST_OUT:  cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // output slot: filled on load, emptied when the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // accepted request always goes to evaluation
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r == ST_EVAL))
    else $error("accepted request did not enter evaluation");

  // divider runs until its last step
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && !status.div_last) |=> (st_r == ST_DIV))
    else $error("divider left early");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output slot overwritten");

  // a finished result waits while the slot is full
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && out_valid_r && !out_ready) |=> (st_r == ST_OUT))
    else $error("result dropped while output stalled");

  // no new request while one is in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ready)
    else $error("ready while busy");
`endif

endmodule

`default_nettype wire

@@ hdl/adsr_dp.sv @@
// adsr_dp: configuration, envelope state, 16x24 multiplier and radix-2 divider
// depends on adsr_pkg; sequenced by adsr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module adsr_dp #(
  parameter int COUNT_WIDTH = adsr_pkg::ADSR_COUNT_WIDTH
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [adsr_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire [adsr_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  adsr_pkg::in_item_t                    in_data,
  output adsr_pkg::out_item_t                   out_data,
  input  adsr_pkg::dp_cmd_t                     cmd,
  output adsr_pkg::dp_status_t                  status
);
  import adsr_pkg::*;

  localparam int EXT_W  = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam int PROD_W = QUO_W + LEN_W;

  // configuration
  logic [LEN_W-1:0] attack_len_r, decay_len_r, release_len_r;
  logic [15:0]      sustain_r;

  // envelope state
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [15:0]            cur_level_r, cur_level_nxt;
  logic [15:0]            rel_start_r, rel_start_nxt;

  // latched request and ramp operands
  in_item_t         req_r;
  logic [15:0]      factor_r, factor_nxt;
  logic [LEN_W-1:0] e24_r, div_r, div_nxt;
  logic [15:0]      base_r, base_nxt;
  logic             sub_r, sub_nxt;
  logic             need_div;

  // divider
  logic [LEN_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic [PROD_W-1:0] prod;
  logic [LEN_W+1:0]  trial;
  logic              ge;

  out_item_t out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r  <= ATTACK_LEN_RST;
      decay_len_r   <= DECAY_LEN_RST;
      sustain_r     <= SUSTAIN_LVL_RST;
      release_len_r <= RELEASE_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ATTACK_LEN:  attack_len_r  <= cfg_data;
        REG_DECAY_LEN:   decay_len_r   <= cfg_data;
        REG_SUSTAIN_LVL: sustain_r     <= cfg_data[15:0];
        REG_RELEASE_LEN: release_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase evaluation for the latched request
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat, e_new;
  logic [EXT_W-1:0]       e_ext;
  logic [15:0]            s_clamp;
  phase_t                 ph_eff;

  always_comb begin
    sum     = {1'b0, elapsed_r} + (COUNT_WIDTH + 1)'(req_r.sample_count);
    sat     = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    e_new   = (phase_r == PH_IDLE) ? '0 : sat;
    ph_eff  = (phase_r == PH_IDLE) ? PH_ATTACK : phase_r;
    e_ext   = EXT_W'(e_new);
    s_clamp = (sustain_r > FULL_SCALE) ? FULL_SCALE : sustain_r;

    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    cur_level_nxt = cur_level_r;
    rel_start_nxt = rel_start_r;
    need_div      = 1'b0;
    factor_nxt    = FULL_SCALE;
    div_nxt       = attack_len_r;
    base_nxt      = FULL_SCALE;
    sub_nxt       = 1'b0;

    if (req_r.req_type == REQ_RELEASE) begin
      elapsed_nxt   = '0;
      rel_start_nxt = cur_level_r;
      phase_nxt     = PH_RELEASE;
    end else begin
      elapsed_nxt = e_new;
      phase_nxt   = ph_eff;
      if (phase_r == PH_IDLE) cur_level_nxt = '0;
      case (ph_eff)
        PH_ATTACK: begin
          if (e_ext < EXT_W'(attack_len_r)) begin
            need_div = 1'b1;
          end else begin
            elapsed_nxt   = '0;
            cur_level_nxt = FULL_SCALE;
            phase_nxt     = PH_DECAY;
          end
        end
        PH_DECAY: begin
          factor_nxt = FULL_SCALE - s_clamp;
          div_nxt    = decay_len_r;
          sub_nxt    = 1'b1;
          if (e_ext < EXT_W'(decay_len_r)) begin
            need_div = 1'b1;
          end else begin
            elapsed_nxt   = '0;
            cur_level_nxt = s_clamp;
            phase_nxt     = PH_SUSTAIN;
          end
        end
        PH_RELEASE: begin
          factor_nxt = rel_start_r;
          div_nxt    = release_len_r;
          base_nxt   = rel_start_r;
          sub_nxt    = 1'b1;
          if (e_ext < EXT_W'(release_len_r)) begin
            need_div = 1'b1;
          end else begin
            cur_level_nxt = '0;
            phase_nxt     = PH_FINISHED;
          end
        end
        default: ;
      endcase
    end
  end

  // multiplier and one restoring divider step
  always_comb begin
    prod  = PROD_W'(factor_r) * PROD_W'(e24_r);
    trial = {1'b0, rem_r, quo_r[QUO_W-1]} - {2'b00, div_r};
    ge    = !trial[LEN_W+1];
  end

  // envelope state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      cur_level_r <= '0;
      rel_start_r <= '0;
    end else if (cmd.eval) begin
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      cur_level_r <= cur_level_nxt;
      rel_start_r <= rel_start_nxt;
    end else if (cmd.fin) begin
      cur_level_r <= sub_r ? (base_r - quo_r) : quo_r;
    end
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.mul) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + STEP_W'(1);
    end
  end

  // request, operands, divider and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) req_r <= in_data;
    if (cmd.eval) begin
      factor_r <= factor_nxt;
      e24_r    <= e_ext[LEN_W-1:0];
      div_r    <= div_nxt;
      base_r   <= base_nxt;
      sub_r    <= sub_nxt;
    end
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:QUO_W];
      quo_r <= prod[QUO_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial[LEN_W-1:0] : {rem_r[LEN_W-2:0], quo_r[QUO_W-1]};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
    if (cmd.out_load) begin
      out_r.level <= cur_level_r;
      out_r.phase <= phase_r;
    end
  end

  assign status.need_div = need_div;
  assign status.div_last = (cnt_r == STEP_W'(QUO_W - 1));
  assign out_data        = out_r;

endmodule

`default_nettype wire

@@ hdl/adsr_envelope_generator.sv @@
// adsr_envelope_generator: top level, joins controller and datapath
// depends on adsr_pkg, adsr_if, adsr_ctrl and adsr_dp
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   req_type, sample_count
//   out_chan  out  valid/ready   level, phase
//   cfg_*     in   cfg_we        cfg_idx, cfg_data
//
// a ramp step goes from accept to result through evaluate, one multiply,
// 16 divider steps (one quotient bit per cycle), final subtract, output load
// release requests and steps without a ramp go from evaluate straight to output load
// a new request is taken once the previous result sits in the output register
// synchronous active-low reset; configuration returns to its defaults
// a stalled output holds the sequencer in its output state until taken
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_generator #(
  parameter int COUNT_WIDTH = adsr_pkg::ADSR_COUNT_WIDTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  adsr_in_if.sink                          in_chan,
  adsr_out_if.source                       out_chan,
  input  wire                              cfg_we,
  input  wire [adsr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import adsr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  adsr_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (in_chan.data),
    .out_data (out_chan.data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

`default_nettype wire

@@ test/tb_adsr_envelope_generator.sv @@
`timescale 1ns / 1ps
// tb_adsr_envelope_generator: self-checking bench for the linear adsr envelope generator
// walks the envelope through attack, decay, sustain and release under changing settings
// depends on adsr_pkg, adsr_if and the adsr_envelope_generator rtl

module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  localparam logic [63:0]      COUNT_MAX    = (64'd1 << ADSR_COUNT_WIDTH) - 64'd1;
  localparam logic [LEN_W-1:0] LEN_MAX      = '1;
  localparam int               HOLD_CYCLES  = 300;
  localparam int unsigned      CYCLE_LIMIT  = 1000000;
  localparam int unsigned      ATTACK_ITEMS = 400;
  localparam int unsigned      DECAY_ITEMS  = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  adsr_in_if  in_chan ();
  adsr_out_if out_chan ();

  adsr_envelope_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predicted envelope state and copies of the registers
  phase_t           env_phase = PH_IDLE;
  logic [63:0]      env_count = '0;
  logic [15:0]      env_level = '0;
  logic [15:0]      rel_start = '0;
  logic [LEN_W-1:0] atk_len   = ATTACK_LEN_RST;
  logic [LEN_W-1:0] dcy_len   = DECAY_LEN_RST;
  logic [15:0]      sus_lvl   = SUSTAIN_LVL_RST;
  logic [LEN_W-1:0] rel_len   = RELEASE_LEN_RST;

  out_item_t   pending_env[$];
  int          env_errors  = 0;
  int unsigned cycle_count = 0;
  int unsigned random_sent = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        long_hold;
  int          hold_count  = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // level and phase after one request; updates the predicted state
  function automatic out_item_t step_envelope(input in_item_t req);
    logic [15:0] sus;
    logic [63:0] drop;
    out_item_t   res;
    sus = (sus_lvl > FULL_SCALE) ? FULL_SCALE : sus_lvl;
    if (req.req_type == REQ_RELEASE) begin
      env_count = '0;
      rel_start = env_level;
      env_phase = PH_RELEASE;
    end else begin
      // sample counter saturates instead of wrapping
      if (env_count > COUNT_MAX - 64'(req.sample_count))
        env_count = COUNT_MAX;
      else
        env_count = env_count + 64'(req.sample_count);
      // first step leaves idle and starts the attack from zero
      if (env_phase == PH_IDLE) begin
        env_count = '0;
        env_level = '0;
        env_phase = PH_ATTACK;
      end
      case (env_phase)
        PH_ATTACK: begin
          if (env_count < 64'(atk_len)) begin
            env_level = 16'((env_count * 64'(FULL_SCALE)) / 64'(atk_len));
          end else begin
            env_count = '0;
            env_level = FULL_SCALE;
            env_phase = PH_DECAY;
          end
        end
        PH_DECAY: begin
          if (env_count < 64'(dcy_len)) begin
            drop      = (64'(FULL_SCALE - sus) * env_count) / 64'(dcy_len);
            env_level = FULL_SCALE - 16'(drop);
          end else begin
            env_count = '0;
            env_level = sus;
            env_phase = PH_SUSTAIN;
          end
        end
        PH_RELEASE: begin
          if (env_count < 64'(rel_len)) begin
            drop      = (64'(rel_start) * env_count) / 64'(rel_len);
            env_level = rel_start - 16'(drop);
          end else begin
            env_level = '0;
            env_phase = PH_FINISHED;
          end
        end
        default: ;
      endcase
    end
    res.level = env_level;
    res.phase = env_phase;
    return res;
  endfunction

  // one request on the input channel, predicted at acceptance
  task automatic send_request(input logic kind, input logic [15:0] samples);
    in_item_t req;
    req.req_type     = kind;
    req.sample_count = samples;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    pending_env.push_back(step_envelope(req));
  endtask

  // stop offering and let every pending result come back
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_env.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_ATTACK_LEN:  atk_len = value;
      REG_DECAY_LEN:   dcy_len = value;
      REG_SUSTAIN_LVL: sus_lvl = value[15:0];
      REG_RELEASE_LEN: rel_len = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ramp length; the ramp in progress gets long lengths so it lasts
  function automatic logic [LEN_W-1:0] pick_length(input logic active);
    logic [LEN_W-1:0] len;
    int unsigned      pick;
    pick = active ? 9 : $urandom_range(9);
    case (pick)
      0:       len = '0;
      1:       len = 24'd1;
      2:       len = LEN_MAX;
      3, 4:    len = 24'($urandom_range(2, 64));
      5, 6:    len = 24'($urandom_range(65, 65535));
      default: len = ($urandom_range(7) == 0) ? LEN_MAX :
                     24'($urandom_range(65536, 32'(LEN_MAX)));
    endcase
    return len;
  endfunction

  // step size scaled to the running ramp, with some extremes mixed in
  function automatic logic [15:0] pick_samples();
    logic [LEN_W-1:0] span;
    logic [LEN_W-1:0] stride;
    logic [15:0]      samples;
    case (env_phase)
      PH_ATTACK:  span = atk_len;
      PH_DECAY:   span = dcy_len;
      PH_RELEASE: span = rel_len;
      default:    span = 24'hFFFF;
    endcase
    stride = (span >> 6) + 24'd1;
    if (stride > 24'hFFFF)
      stride = 24'hFFFF;
    case ($urandom_range(9))
      0:       samples = 16'd0;
      1:       samples = 16'hFFFF;
      2, 3:    samples = 16'($urandom);
      default: samples = 16'($urandom_range(0, 32'(stride)));
    endcase
    return samples;
  endfunction

  // release events only once the ramps have had their run
  function automatic logic pick_kind();
    logic kind;
    case (env_phase)
      PH_SUSTAIN:  kind = ($urandom_range(5) == 0) ? REQ_RELEASE : REQ_STEP;
      PH_RELEASE:  kind = ($urandom_range(11) == 0) ? REQ_RELEASE : REQ_STEP;
      PH_FINISHED: kind = ($urandom_range(3) == 0) ? REQ_RELEASE : REQ_STEP;
      default:     kind = REQ_STEP;
    endcase
    return kind;
  endfunction

  // receiver: random stalls, or one long hold counted here
  always @(negedge clk) begin
    if (long_hold) begin
      out_chan.ready <= 1'b0;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_count <= 0;
        long_hold  <= 1'b0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_env.size() == 0) begin
        $error("unexpected result: level %0d phase %0d",
               out_chan.data.level, out_chan.data.phase);
        env_errors++;
      end else begin
        want = pending_env.pop_front();
        if (out_chan.data.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_chan.data.level);
          env_errors++;
        end
        if (out_chan.data.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, out_chan.data.phase);
          env_errors++;
        end
      end
    end
  end

  // attack from reset defaults: start, one below full length, longest length
  task automatic test_attack_ramp();
    send_request(REQ_STEP, 16'd0);
    send_request(REQ_STEP, 16'd1);
    send_request(REQ_STEP, 16'd219);
    send_request(REQ_STEP, 16'd220);
    wait_drained();
    write_reg(REG_ATTACK_LEN, LEN_MAX);
    send_request(REQ_STEP, 16'hFFFF);
    send_request(REQ_STEP, 16'd0);
    send_request(REQ_STEP, 16'hFFFF);
  endtask

  // random walk through the envelope, new settings between bursts
  task automatic test_random_envelope(input int unsigned items,
                                      input int unsigned tx_pct,
                                      input int unsigned rx_pct);
    int unsigned left;
    int unsigned burst;
    logic [15:0] sus;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    left        = items;
    while (left != 0) begin
      wait_drained();
      // zero lengths end a ramp that has gone on long enough
      if (env_phase == PH_ATTACK && random_sent >= ATTACK_ITEMS)
        write_reg(REG_ATTACK_LEN, '0);
      else if ($urandom_range(1) == 0)
        write_reg(REG_ATTACK_LEN, pick_length(env_phase == PH_ATTACK));
      if (env_phase == PH_DECAY && random_sent >= DECAY_ITEMS)
        write_reg(REG_DECAY_LEN, '0);
      else if ($urandom_range(1) == 0)
        write_reg(REG_DECAY_LEN, pick_length(env_phase == PH_DECAY));
      if ($urandom_range(1) == 0)
        write_reg(REG_RELEASE_LEN, pick_length(env_phase == PH_RELEASE));
      // sustain above full scale is clamped; upper data bits are don't-care
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(5))
          0:       sus = '0;
          1:       sus = FULL_SCALE;
          2:       sus = 16'($urandom_range(32769, 65535));
          default: sus = 16'($urandom_range(0, 32768));
        endcase
        write_reg(REG_SUSTAIN_LVL, {8'($urandom), sus});
      end
      burst = $urandom_range(40, 120);
      if (burst > left)
        burst = left;
      repeat (burst) begin
        send_request(pick_kind(), pick_samples());
        random_sent++;
      end
      left -= burst;
    end
  endtask

  // receiver holds off while requests keep coming, then a full drain
  task automatic test_output_stall();
    tx_idle_pct = 0;
    wait_drained();
    @(posedge clk);
    long_hold = 1'b1;
    repeat (24) send_request(pick_kind(), pick_samples());
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    long_hold      = 1'b0;
    tx_idle_pct    = 22;
    rx_idle_pct    = 85;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_attack_ramp();
    test_random_envelope(630, 22, 85);
    test_random_envelope(630, 85, 22);
    test_output_stall();
    test_random_envelope(600, 0, 0);

    wait_drained();
    repeat (30) @(posedge clk);
    if (env_errors == 0 && pending_env.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
